// File: src/piecewise_linear_calibration_table_defines.svh
// ----------------------------------------------------------------------------
// Calibration table assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CALIBRATION_TABLE_DEFINES_SVH
`define PIECEWISE_LINEAR_CALIBRATION_TABLE_DEFINES_SVH

// same-cycle implication
`define PWLCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PWLCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pwlct_pkg.sv
// ----------------------------------------------------------------------------
// Calibration table package
// Widths, codes and the types shared by controller and datapath.
// ----------------------------------------------------------------------------
package pwlct_pkg;

  localparam int unsigned MaxPointsDef = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned IdxW         = 4;
  localparam int unsigned CountOutW    = 5;
  localparam int unsigned FracW        = 16;
  // quotient bits of a Q16.16 slope from a 33-bit difference
  localparam int unsigned DivSteps     = DataW + 1 + FracW;
  localparam int unsigned DivCntW      = $clog2(DivSteps);
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [DataW-1:0] SlopeMax = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] SlopeMin = 32'h8000_0000;

  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_ZSHIFT = 2'd1,
    REQ_ADD    = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SAT   = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZERO_RAW_INIT = 1'b0,
    CFG_ZERO_SHIFT    = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    WR_INIT,
    WR_ZSHIFT,
    WR_COPY,
    WR_REPLACE,
    WR_NEW,
    WR_SLOPE,
    WR_LAST
  } wr_sel_e;

  typedef struct packed {
    logic [DataW-1:0] raw;
    logic [DataW-1:0] weight;
    logic [DataW-1:0] slope;
  } entry_t;

  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cap;
    logic    cnt_set1;
    logic    cnt_inc;
    logic    prev_ld;
    logic    div_start;
    logic    advance;
    logic    out_ld;
    status_e status;
    logic    out_entry;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_ge;
    logic rd_eq;
    logic div_done;
  } dp_stat_t;

endpackage

// File: src/pwlct_if.sv
// ----------------------------------------------------------------------------
// Calibration table channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pwlct_req_if
  import pwlct_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [DataW-1:0] sample_raw;
  logic signed [DataW-1:0] known_weight;
  logic [IdxW-1:0]         entry_index;

  modport source (output valid, req_type, sample_raw, known_weight, entry_index,
                  input ready);
  modport sink   (input valid, req_type, sample_raw, known_weight, entry_index,
                  output ready);
endinterface

interface pwlct_rsp_if
  import pwlct_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CountOutW-1:0]    section_count;
  logic signed [DataW-1:0] entry_raw;
  logic signed [DataW-1:0] entry_weight;
  logic signed [DataW-1:0] entry_ratio;
  logic [1:0]              status;

  modport source (output valid, section_count, entry_raw, entry_weight, entry_ratio,
                  status, input ready);
  modport sink   (input valid, section_count, entry_raw, entry_weight, entry_ratio,
                  status, output ready);
endinterface

// File: src/piecewise_linear_calibration_table.sv
// ----------------------------------------------------------------------------
// Piecewise-linear calibration table
// Load-cell calibration points sorted by weight, with Q16.16 slopes.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one response. A read fetches the
// indexed point, init writes the zero point, and a zero shift reads and rewrites
// each stored point. An add searches the stored points, moves points up to make
// room, and then recomputes count - 1 slopes with the 49-step bit-serial divider,
// plus the memory read and write-back of each point. The points live in a single
// port memory. The response sits in an output register, so a new request is
// taken while the previous response waits to be collected.
module piecewise_linear_calibration_table
  import pwlct_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pwlct_req_if.sink          req_i,
  pwlct_rsp_if.source        rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [CW-1:0] count;
  logic [AW-1:0] addr;

  pwlct_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_ready_o    (req_i.ready),
    .req_type_i    (req_i.req_type),
    .entry_index_i (req_i.entry_index),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .count_i       (count),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .addr_o        (addr)
  );

  pwlct_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_raw_i    (req_i.sample_raw),
    .known_weight_i  (req_i.known_weight),
    .cmd_i           (cmd),
    .addr_i          (addr),
    .count_o         (count),
    .stat_o          (stat),
    .section_count_o (rsp_o.section_count),
    .entry_raw_o     (rsp_o.entry_raw),
    .entry_weight_o  (rsp_o.entry_weight),
    .entry_ratio_o   (rsp_o.entry_ratio),
    .status_o        (rsp_o.status)
  );

endmodule

// File: src/pwlct_div.sv
// ----------------------------------------------------------------------------
// Slope divider
// Restoring divider, one quotient bit per cycle, Q16.16 result with saturation.
// ----------------------------------------------------------------------------
module pwlct_div
  import pwlct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW:0]   dw_i,
  input  logic [DataW:0]   dr_i,
  output logic             done_o,
  output logic [DataW-1:0] slope_o,
  output logic             sat_o
);

  localparam int unsigned DvdW = DivSteps;

  logic               busy_q, fin_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvdW-1:0]    dvd_q;
  logic [DataW:0]     rem_q, rem_d;
  logic [DataW:0]     ad_q;
  logic               neg_q;
  logic [DataW-1:0]   slope_q;
  logic               sat_q;

  logic [DataW:0]   mag_dw, mag_dr;
  logic             dr_zero, dw_zero;
  logic [DataW+1:0] trial;
  logic             ge;

  assign mag_dw  = dw_i[DataW] ? (~dw_i + 1'b1) : dw_i;
  assign mag_dr  = dr_i[DataW] ? (~dr_i + 1'b1) : dr_i;
  assign dr_zero = (dr_i == '0);
  assign dw_zero = (dw_i == '0);

  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign ge    = (trial >= {1'b0, ad_q});
  // remainder stays below the divisor, so it fits in DataW+1 bits
  assign rem_d = ge ? (DataW+1)'(trial - {1'b0, ad_q}) : trial[DataW:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (dr_zero) begin
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= (dw_i[DataW] != dr_i[DataW]) && !dw_zero;
      dvd_q <= {mag_dw, FracW'(0)};
      rem_q <= '0;
      ad_q  <= mag_dr;
      if (dr_zero) begin
        sat_q   <= 1'b1;
        slope_q <= dw_i[DataW] ? SlopeMin : SlopeMax;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DvdW-2:0], ge};
    end else if (fin_q) begin
      if (neg_q) begin
        if (dvd_q > DvdW'(SlopeMin)) begin
          sat_q   <= 1'b1;
          slope_q <= SlopeMin;
        end else begin
          sat_q   <= 1'b0;
          slope_q <= DataW'(0) - dvd_q[DataW-1:0];
        end
      end else begin
        if (dvd_q > DvdW'(SlopeMax)) begin
          sat_q   <= 1'b1;
          slope_q <= SlopeMax;
        end else begin
          sat_q   <= 1'b0;
          slope_q <= dvd_q[DataW-1:0];
        end
      end
    end
  end

  assign done_o  = done_q;
  assign slope_o = slope_q;
  assign sat_o   = sat_q;

endmodule

// File: src/pwlct_dp.sv
// ----------------------------------------------------------------------------
// Calibration table datapath
// Point memory, point count, operand registers, slope divider, result register.
// ----------------------------------------------------------------------------
`include "piecewise_linear_calibration_table_defines.svh"

module pwlct_dp
  import pwlct_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [DataW-1:0]        cfg_wdata_i,
  input  logic [DataW-1:0]        sample_raw_i,
  input  logic [DataW-1:0]        known_weight_i,
  input  dp_cmd_t                 cmd_i,
  input  logic [AW-1:0]           addr_i,
  output logic [CW-1:0]           count_o,
  output dp_stat_t                stat_o,
  output logic [CountOutW-1:0]    section_count_o,
  output logic [DataW-1:0]        entry_raw_o,
  output logic [DataW-1:0]        entry_weight_o,
  output logic [DataW-1:0]        entry_ratio_o,
  output logic [1:0]              status_o
);

  entry_t           mem [MAX_POINTS];
  entry_t           rdata_q;
  entry_t           wdata;
  entry_t           prev_q, cur_q;
  logic [DataW-1:0] last_q;
  logic [DataW-1:0] raw_q, wt_q;
  logic [DataW-1:0] zri_q, zs_q;
  logic [CW-1:0]    count_q;
  logic             sat_q;

  logic [CountOutW-1:0] sc_q;
  logic [DataW-1:0]     er_q, ew_q, es_q;
  logic [1:0]           st_q;

  logic [DataW:0]   dw, dr;
  logic             div_done, div_sat;
  logic [DataW-1:0] div_slope;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zri_q <= '0;
      zs_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ZERO_RAW_INIT: zri_q <= cfg_wdata_i;
        CFG_ZERO_SHIFT:    zs_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    wdata = rdata_q;
    unique case (cmd_i.wr_sel)
      WR_INIT:    wdata = '{raw: zri_q, weight: '0, slope: '0};
      WR_ZSHIFT:  wdata = '{raw: rdata_q.raw - zs_q, weight: rdata_q.weight,
                            slope: rdata_q.slope};
      WR_COPY:    wdata = rdata_q;
      WR_REPLACE: wdata = '{raw: raw_q, weight: rdata_q.weight, slope: rdata_q.slope};
      WR_NEW:     wdata = '{raw: raw_q, weight: wt_q, slope: '0};
      WR_SLOPE:   wdata = '{raw: prev_q.raw, weight: prev_q.weight, slope: div_slope};
      WR_LAST:    wdata = '{raw: prev_q.raw, weight: prev_q.weight, slope: last_q};
      default:    wdata = rdata_q;
    endcase
  end

  // point memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[addr_i] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      if (cmd_i.cnt_set1) begin
        count_q <= CW'(1);
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.cap) begin
        sat_q <= 1'b0;
      end else if (cmd_i.advance) begin
        sat_q <= sat_q | div_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      raw_q <= sample_raw_i;
      wt_q  <= known_weight_i;
    end
    if (cmd_i.prev_ld) begin
      prev_q <= rdata_q;
    end else if (cmd_i.advance) begin
      prev_q <= cur_q;
    end
    if (cmd_i.div_start) begin
      cur_q <= rdata_q;
    end
    if (cmd_i.advance) begin
      last_q <= div_slope;
    end
    if (cmd_i.out_ld) begin
      sc_q <= CountOutW'(count_q);
      er_q <= cmd_i.out_entry ? rdata_q.raw    : '0;
      ew_q <= cmd_i.out_entry ? rdata_q.weight : '0;
      es_q <= cmd_i.out_entry ? rdata_q.slope  : '0;
      st_q <= ((cmd_i.status == ST_OK) && sat_q) ? ST_SAT : cmd_i.status;
    end
  end

  // exact 33-bit differences toward the next point
  assign dw = {rdata_q.weight[DataW-1], rdata_q.weight} - {prev_q.weight[DataW-1], prev_q.weight};
  assign dr = {rdata_q.raw[DataW-1], rdata_q.raw} - {prev_q.raw[DataW-1], prev_q.raw};

  pwlct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dw_i    (dw),
    .dr_i    (dr),
    .done_o  (div_done),
    .slope_o (div_slope),
    .sat_o   (div_sat)
  );

  assign stat_o.rd_ge    = ($signed(rdata_q.weight) >= $signed(wt_q));
  assign stat_o.rd_eq    = (rdata_q.weight == wt_q);
  assign stat_o.div_done = div_done;
  assign count_o         = count_q;

  assign section_count_o = sc_q;
  assign entry_raw_o     = er_q;
  assign entry_weight_o  = ew_q;
  assign entry_ratio_o   = es_q;
  assign status_o        = st_q;

  `PWLCT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_POINTS), "point count above capacity")
  `PWLCT_ASSERT_NOW(a_no_insert_full, cmd_i.cnt_inc, count_q < CW'(MAX_POINTS), "insert into full table")

endmodule

// File: src/pwlct_ctrl.sv
// ----------------------------------------------------------------------------
// Calibration table controller
// Sequences init, search, shift, insert, slope recompute, zero shift and read.
// ----------------------------------------------------------------------------
`include "piecewise_linear_calibration_table_defines.svh"

module pwlct_ctrl
  import pwlct_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      req_type_i,
  input  logic [IdxW-1:0] entry_index_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic [CW-1:0]   count_i,
  input  dp_stat_t        stat_i,
  output dp_cmd_t         cmd_o,
  output logic [AW-1:0]   addr_o
);

  localparam int unsigned CmpW = (CW > IdxW) ? CW : IdxW;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ZS_RD,
    S_ZS_WR,
    S_SR_RD,
    S_SR_CMP,
    S_REP_WR,
    S_INS_CHK,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_RC_CHK,
    S_RC_LD0,
    S_RC_RD,
    S_RC_DIV,
    S_RC_WAIT,
    S_RC_WR,
    S_RC_LAST,
    S_RD_RD,
    S_FIN
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   i_q, pos_q;
  logic [IdxW-1:0] idx_q;
  status_e         st_q;
  logic            ent_q;
  logic            out_valid_q;

  logic          accept;
  logic [CW-1:0] i_inc, i_dec;
  logic          full;
  logic          idx_ok;
  logic          out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign i_inc    = i_q + 1'b1;
  assign i_dec    = i_q - 1'b1;
  assign full     = (count_i == CW'(MAX_POINTS));
  assign idx_ok   = (CmpW'(entry_index_i) < CmpW'(count_i));
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      st_q        <= ST_OK;
      ent_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q <= entry_index_i;
            st_q  <= ST_OK;
            ent_q <= 1'b0;
            i_q   <= '0;
            pos_q <= count_i;
            unique case (req_type_e'(req_type_i))
              REQ_INIT:   state_q <= S_FIN;
              REQ_ZSHIFT: state_q <= (count_i == '0) ? S_FIN : S_ZS_RD;
              REQ_ADD:    state_q <= (count_i == '0) ? S_INS_CHK : S_SR_RD;
              REQ_READ: begin
                if (idx_ok) begin
                  state_q <= S_RD_RD;
                end else begin
                  st_q    <= ST_RANGE;
                  state_q <= S_FIN;
                end
              end
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_ZS_RD: state_q <= S_ZS_WR;
        S_ZS_WR: begin
          i_q     <= i_inc;
          state_q <= (i_inc == count_i) ? S_FIN : S_ZS_RD;
        end
        S_SR_RD: state_q <= S_SR_CMP;
        S_SR_CMP: begin
          priority if (stat_i.rd_ge) begin
            pos_q   <= i_q;
            state_q <= stat_i.rd_eq ? S_REP_WR : S_INS_CHK;
          end else if (i_inc == count_i) begin
            state_q <= S_INS_CHK;
          end else begin
            i_q     <= i_inc;
            state_q <= S_SR_RD;
          end
        end
        S_REP_WR: state_q <= S_RC_CHK;
        S_INS_CHK: begin
          priority if (full) begin
            st_q    <= ST_FULL;
            state_q <= S_FIN;
          end else begin
            i_q     <= count_i;
            state_q <= (count_i > pos_q) ? S_SH_RD : S_INS_WR;
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          i_q     <= i_dec;
          state_q <= (i_dec == pos_q) ? S_INS_WR : S_SH_RD;
        end
        S_INS_WR: state_q <= S_RC_CHK;
        S_RC_CHK: state_q <= (count_i < CW'(2)) ? S_FIN : S_RC_LD0;
        S_RC_LD0: begin
          i_q     <= CW'(1);
          state_q <= S_RC_RD;
        end
        S_RC_RD:   state_q <= S_RC_DIV;
        S_RC_DIV:  state_q <= S_RC_WAIT;
        S_RC_WAIT: state_q <= stat_i.div_done ? S_RC_WR : S_RC_WAIT;
        S_RC_WR: begin
          if (i_inc == count_i) begin
            state_q <= S_RC_LAST;
          end else begin
            i_q     <= i_inc;
            state_q <= S_RC_RD;
          end
        end
        S_RC_LAST: state_q <= S_FIN;
        S_RD_RD: begin
          ent_q   <= 1'b1;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.rd_en     = 1'b0;
    cmd_o.wr_en     = 1'b0;
    cmd_o.wr_sel    = WR_COPY;
    cmd_o.cap       = 1'b0;
    cmd_o.cnt_set1  = 1'b0;
    cmd_o.cnt_inc   = 1'b0;
    cmd_o.prev_ld   = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.advance   = 1'b0;
    cmd_o.out_ld    = 1'b0;
    cmd_o.status    = st_q;
    cmd_o.out_entry = ent_q;
    addr_o          = AW'(i_q);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.cap = accept;
        addr_o    = '0;
        if (accept && (req_type_e'(req_type_i) == REQ_INIT)) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_sel   = WR_INIT;
          cmd_o.cnt_set1 = 1'b1;
        end
      end
      S_ZS_RD: cmd_o.rd_en = 1'b1;
      S_ZS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_ZSHIFT;
      end
      S_SR_RD: cmd_o.rd_en = 1'b1;
      S_REP_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_REPLACE;
      end
      S_SH_RD: begin
        cmd_o.rd_en = 1'b1;
        addr_o      = AW'(i_dec);
      end
      S_SH_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_COPY;
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_NEW;
        cmd_o.cnt_inc = 1'b1;
        addr_o        = AW'(pos_q);
      end
      S_RC_CHK: begin
        cmd_o.rd_en = (count_i >= CW'(2));
        addr_o      = '0;
      end
      S_RC_LD0:  cmd_o.prev_ld = 1'b1;
      S_RC_RD:   cmd_o.rd_en = 1'b1;
      S_RC_DIV:  cmd_o.div_start = 1'b1;
      S_RC_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_SLOPE;
        cmd_o.advance = 1'b1;
        addr_o        = AW'(i_dec);
      end
      S_RC_LAST: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_LAST;
      end
      S_RD_RD: begin
        cmd_o.rd_en = 1'b1;
        addr_o      = AW'(idx_q);
      end
      S_FIN: cmd_o.out_ld = out_free;
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `PWLCT_ASSERT_NOW(a_rd_wr_excl, cmd_o.rd_en, !cmd_o.wr_en, "memory read and write together")
  `PWLCT_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accepted request not started")
  `PWLCT_ASSERT_NEXT(a_fin_loads, (state_q == S_FIN) && out_free, out_valid_q, "result not shown")

endmodule
